// ----- sv/sq_pkg.sv -----
// sq_pkg: shared types and command codes for the subleq core
// used by the channel interfaces and by subleq_processor
`timescale 1ns / 1ps

package sq_pkg;

    typedef logic [1:0]         cmd_t;
    typedef logic [14:0]        addr_t;
    typedef logic signed [15:0] word_t;
    typedef logic [7:0]         byte_t;

    localparam cmd_t CMD_LOAD = 2'd0;
    localparam cmd_t CMD_EXEC = 2'd1;
    localparam cmd_t CMD_READ = 2'd2;

endpackage

// ----- sv/sq_ifs.sv -----
// sq_cmd_if and sq_rsp_if: valid/ready channels of the subleq core
// depends on sq_pkg for the payload types
`timescale 1ns / 1ps

interface sq_cmd_if;
    logic          valid;
    logic          ready;
    sq_pkg::cmd_t  command;
    sq_pkg::addr_t address;
    sq_pkg::word_t write_value;
    sq_pkg::byte_t in_byte;
    logic          in_eof;

    modport source (output valid, command, address, write_value, in_byte, in_eof,
                    input ready);
    modport sink (input valid, command, address, write_value, in_byte, in_eof,
                  output ready);
endinterface

interface sq_rsp_if;
    logic          valid;
    logic          ready;
    logic          halted;
    logic          out_valid;
    sq_pkg::byte_t out_byte;
    logic          in_consumed;
    sq_pkg::word_t read_data;
    sq_pkg::addr_t program_counter;

    modport source (output valid, halted, out_valid, out_byte, in_consumed, read_data,
                    program_counter, input ready);
    modport sink (input valid, halted, out_valid, out_byte, in_consumed, read_data,
                  program_counter, output ready);
endinterface

// ----- sv/subleq_processor.sv -----
// subleq_processor: 16-bit subleq core with a single-port word memory and a sequencer
// depends on sq_pkg and the channel interfaces in sq_ifs.sv
// one beat at a time; the single memory port serialises the work: 3 fetches, operand reads, write
// rst_n clears pc, halt flag and sequencer at once; memory contents are not cleared
`timescale 1ns / 1ps

module subleq_processor #(
    parameter int ADDR_BITS = 15
) (
    input  logic     clk,
    input  logic     rst_n,
    sq_cmd_if.sink   cmd,
    sq_rsp_if.source rsp
);

    localparam int MEM_WORDS = 1 << ADDR_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FA   = 4'd1;
    localparam logic [3:0] S_FB   = 4'd2;
    localparam logic [3:0] S_FC   = 4'd3;
    localparam logic [3:0] S_DEC  = 4'd4;
    localparam logic [3:0] S_OUT  = 4'd5;
    localparam logic [3:0] S_RDB  = 4'd6;
    localparam logic [3:0] S_SUB  = 4'd7;
    localparam logic [3:0] S_READ = 4'd8;
    localparam logic [3:0] S_RDAT = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [15:0] pc_reg, pc_next;
    logic        halt_reg, halt_next;
    logic        rv_valid_reg, rv_valid_next;

    logic [15:0] a_reg, a_next;
    logic [15:0] b_reg, b_next;
    logic [15:0] c_reg, c_next;
    logic [15:0] aval_reg, aval_next;
    logic [15:0] pc3_reg, pc3_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [7:0]  inb_reg, inb_next;
    logic        eof_reg, eof_next;
    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg, ob_next;
    logic        cons_reg, cons_next;
    logic [15:0] rv_reg, rv_next;

    logic        o_halt_reg, o_halt_next;
    logic        o_ov_reg, o_ov_next;
    logic [7:0]  o_ob_reg, o_ob_next;
    logic        o_cons_reg, o_cons_next;
    logic [15:0] o_rv_reg, o_rv_next;
    logic [14:0] o_pc_reg, o_pc_next;

    logic [15:0] mem [MEM_WORDS];
    logic [15:0] rdata_reg;
    logic        mem_we;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [15:0] mem_wdata;

    logic [15:0] alu_x, alu_y, alu_sum;
    logic        alu_ci;
    logic [15:0] npc;
    logic        cmd_fire;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;

    // shared adder: fetch offsets, pc+3 and the subtract
    assign alu_sum = alu_x + alu_y + {15'd0, alu_ci};

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        halt_next   = halt_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        aval_next   = aval_reg;
        pc3_next    = pc3_reg;
        addr_next   = addr_reg;
        inb_next    = inb_reg;
        eof_next    = eof_reg;
        ov_next     = ov_reg;
        ob_next     = ob_reg;
        cons_next   = cons_reg;
        rv_next     = rv_reg;
        o_halt_next = o_halt_reg;
        o_ov_next   = o_ov_reg;
        o_ob_next   = o_ob_reg;
        o_cons_next = o_cons_reg;
        o_rv_next   = o_rv_reg;
        o_pc_next   = o_pc_reg;
        rv_valid_next = rv_valid_reg && !rsp.ready;
        mem_we      = 1'b0;
        mem_addr    = pc_reg[ADDR_BITS-1:0];
        mem_wdata   = alu_sum;
        alu_x       = pc_reg;
        alu_y       = 16'd0;
        alu_ci      = 1'b0;
        npc         = pc3_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    addr_next = cmd.address[ADDR_BITS-1:0];
                    inb_next  = cmd.in_byte;
                    eof_next  = cmd.in_eof;
                    ov_next   = 1'b0;
                    ob_next   = 8'd0;
                    cons_next = 1'b0;
                    rv_next   = 16'd0;
                    case (cmd.command)
                        sq_pkg::CMD_LOAD:
                        begin
                            mem_we     = 1'b1;
                            mem_addr   = cmd.address[ADDR_BITS-1:0];
                            mem_wdata  = cmd.write_value;
                            state_next = S_DONE;
                        end
                        sq_pkg::CMD_EXEC:
                            state_next = halt_reg ? S_DONE : S_FA;
                        sq_pkg::CMD_READ:
                            state_next = S_READ;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_FA:
            begin
                mem_addr   = pc_reg[ADDR_BITS-1:0];
                state_next = S_FB;
            end
            S_FB:
            begin
                alu_y      = 16'd1;
                mem_addr   = alu_sum[ADDR_BITS-1:0];
                a_next     = rdata_reg;
                state_next = S_FC;
            end
            S_FC:
            begin
                alu_y      = 16'd2;
                mem_addr   = alu_sum[ADDR_BITS-1:0];
                b_next     = rdata_reg;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                c_next   = rdata_reg;
                alu_y    = 16'd3;
                pc3_next = alu_sum;
                mem_addr = a_reg[ADDR_BITS-1:0];
                if (a_reg[15])
                begin
                    // input instruction
                    cons_next = 1'b1;
                    if (!b_reg[15])
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = b_reg[ADDR_BITS-1:0];
                        mem_wdata = eof_reg ? 16'hFFFF : {8'd0, inb_reg};
                    end
                    pc_next    = alu_sum;
                    halt_next  = alu_sum[15];
                    state_next = S_DONE;
                end
                else if (b_reg[15])
                    state_next = S_OUT;
                else
                    state_next = S_RDB;
            end
            S_OUT:
            begin
                ov_next    = 1'b1;
                ob_next    = rdata_reg[7:0];
                pc_next    = pc3_reg;
                halt_next  = pc3_reg[15];
                state_next = S_DONE;
            end
            S_RDB:
            begin
                aval_next  = rdata_reg;
                mem_addr   = b_reg[ADDR_BITS-1:0];
                state_next = S_SUB;
            end
            S_SUB:
            begin
                alu_x     = rdata_reg;
                alu_y     = ~aval_reg;
                alu_ci    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = b_reg[ADDR_BITS-1:0];
                mem_wdata = alu_sum;
                if (alu_sum == 16'd0 || alu_sum[15])
                    npc = c_reg;
                pc_next    = npc;
                halt_next  = npc[15];
                state_next = S_DONE;
            end
            S_READ:
            begin
                mem_addr   = addr_reg;
                state_next = S_RDAT;
            end
            S_RDAT:
            begin
                rv_next    = rdata_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rv_valid_reg || rsp.ready)
                begin
                    o_halt_next   = halt_reg;
                    o_ov_next     = ov_reg;
                    o_ob_next     = ob_reg;
                    o_cons_next   = cons_reg;
                    o_rv_next     = rv_reg;
                    o_pc_next     = pc_reg[14:0];
                    rv_valid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pc_reg       <= 16'd0;
            halt_reg     <= 1'b0;
            rv_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            halt_reg     <= halt_next;
            rv_valid_reg <= rv_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        aval_reg   <= aval_next;
        pc3_reg    <= pc3_next;
        addr_reg   <= addr_next;
        inb_reg    <= inb_next;
        eof_reg    <= eof_next;
        ov_reg     <= ov_next;
        ob_reg     <= ob_next;
        cons_reg   <= cons_next;
        rv_reg     <= rv_next;
        o_halt_reg <= o_halt_next;
        o_ov_reg   <= o_ov_next;
        o_ob_reg   <= o_ob_next;
        o_cons_reg <= o_cons_next;
        o_rv_reg   <= o_rv_next;
        o_pc_reg   <= o_pc_next;
    end

    // word memory, single port with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    assign rsp.valid           = rv_valid_reg;
    assign rsp.halted          = o_halt_reg;
    assign rsp.out_valid       = o_ov_reg;
    assign rsp.out_byte        = o_ob_reg;
    assign rsp.in_consumed     = o_cons_reg;
    assign rsp.read_data       = o_rv_reg;
    assign rsp.program_counter = o_pc_reg;

    // no writes while fetching the instruction words
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FA || state_reg == S_FB || state_reg == S_FC) |-> !mem_we)
        else $error("memory write during fetch");

    // halt is sticky
    assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");

    // pc frozen once halted
    assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> $stable(pc_reg))
        else $error("pc moved while halted");

    // a finished beat reaches the output register when the slot is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!rv_valid_reg || rsp.ready)) |=> (rv_valid_reg && state_reg == S_IDLE))
        else $error("result not presented");

endmodule

// ----- test/sq_status_check.sv -----
// sq_status_check: predicts every status beat of subleq_processor and compares it
// watches the sq_cmd_if and sq_rsp_if channels; needs sq_pkg and sv/sq_ifs.sv
`timescale 1ns / 1ps

module sq_status_check (
    input  logic clk,
    input  logic rst_n,
    sq_cmd_if    cmd,
    sq_rsp_if    rsp,
    output int   fail_count,
    output int   pending,
    output int   checked
);

    typedef struct {
        logic          halted;
        logic          out_valid;
        sq_pkg::byte_t out_byte;
        logic          in_consumed;
        sq_pkg::word_t read_data;
        sq_pkg::addr_t program_counter;
    } status_t;

    logic [15:0] word_mem [0:32767];
    logic [15:0] core_pc;
    logic        core_halted;
    status_t     status_q[$];
    int          n_fail = 0;
    int          n_pending = 0;
    int          n_checked = 0;

    assign fail_count = n_fail;
    assign pending    = n_pending;
    assign checked    = n_checked;

    task automatic flag_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
        if (n_fail < 100)
            $display("%0t: %s mismatch, got %h, expected %h", $time, field, got, want);
        n_fail++;
    endtask

    function automatic status_t apply_command(input sq_pkg::cmd_t op,
                                              input sq_pkg::addr_t addr,
                                              input sq_pkg::word_t value,
                                              input sq_pkg::byte_t ch,
                                              input logic eof);
        status_t       st;
        sq_pkg::addr_t fa;
        sq_pkg::addr_t fb;
        sq_pkg::addr_t fc;
        logic [15:0]   a;
        logic [15:0]   b;
        logic [15:0]   c;
        logic [15:0]   nxt;
        logic [15:0]   diff;
        st.out_valid   = 1'b0;
        st.out_byte    = '0;
        st.in_consumed = 1'b0;
        st.read_data   = '0;
        case (op)
            sq_pkg::CMD_LOAD: word_mem[addr] = value;
            sq_pkg::CMD_READ: st.read_data = word_mem[addr];
            sq_pkg::CMD_EXEC:
                if (!core_halted)
                begin
                    fa  = core_pc[14:0];
                    fb  = fa + 15'd1;
                    fc  = fa + 15'd2;
                    a   = word_mem[fa];
                    b   = word_mem[fb];
                    c   = word_mem[fc];
                    nxt = core_pc + 16'd3;
                    if (a[15])
                    begin
                        st.in_consumed = 1'b1;
                        if (!b[15])
                            word_mem[b[14:0]] = eof ? 16'hFFFF : {8'h00, ch};
                    end
                    else if (b[15])
                    begin
                        st.out_valid = 1'b1;
                        st.out_byte  = word_mem[a[14:0]][7:0];
                    end
                    else
                    begin
                        diff = word_mem[b[14:0]] - word_mem[a[14:0]];
                        word_mem[b[14:0]] = diff;
                        if (diff == 16'd0 || diff[15])
                            nxt = c;
                    end
                    core_pc = nxt;
                    if (nxt[15])
                        core_halted = 1'b1;
                end
            default: ;
        endcase
        st.halted          = core_halted;
        st.program_counter = core_pc[14:0];
        return st;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        status_t want;
        if (!rst_n)
        begin
            core_pc     = '0;
            core_halted = 1'b0;
            status_q.delete();
            n_pending   = 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                status_q.push_back(apply_command(cmd.command, cmd.address, cmd.write_value,
                                                 cmd.in_byte, cmd.in_eof));
                n_pending++;
            end
            if (rsp.valid && rsp.ready)
            begin
                n_checked++;
                if (status_q.size() == 0)
                    flag_mismatch("unexpected beat, pc", 16'(rsp.program_counter), '0);
                else
                begin
                    want = status_q.pop_front();
                    n_pending--;
                    if (rsp.halted !== want.halted)
                        flag_mismatch("halted", 16'(rsp.halted), 16'(want.halted));
                    if (rsp.out_valid !== want.out_valid)
                        flag_mismatch("out_valid", 16'(rsp.out_valid), 16'(want.out_valid));
                    if (rsp.out_byte !== want.out_byte)
                        flag_mismatch("out_byte", 16'(rsp.out_byte), 16'(want.out_byte));
                    if (rsp.in_consumed !== want.in_consumed)
                        flag_mismatch("in_consumed", 16'(rsp.in_consumed),
                                      16'(want.in_consumed));
                    if (rsp.read_data !== want.read_data)
                        flag_mismatch("read_data", rsp.read_data, want.read_data);
                    if (rsp.program_counter !== want.program_counter)
                        flag_mismatch("program_counter", 16'(rsp.program_counter),
                                      16'(want.program_counter));
                end
            end
        end
    end

endmodule

// ----- test/tb_subleq_processor.sv -----
// tb_subleq_processor: drives load, read and execute commands into subleq_processor
// builds small programs at the tracked pc; sq_status_check predicts and compares
// needs sq_pkg, sv/sq_ifs.sv, the core and test/sq_status_check.sv
`timescale 1ns / 1ps

module tb_subleq_processor;

    localparam sq_pkg::cmd_t CMD_UNUSED   = 2'd3;
    localparam int           QUIET_LIMIT  = 2000;
    localparam int           RANDOM_BEATS = 1600;
    localparam int           PHASES       = 8;

    typedef enum { INS_SUB, INS_BLIND, INS_INPUT, INS_DROP, INS_OUTPUT } instr_t;

    logic clk = 1'b0;
    logic rst_n;

    sq_cmd_if cmd_if ();
    sq_rsp_if rsp_if ();

    int            fail_count;
    int            pending;
    int            checked;
    int            send_idle = 0;
    int            recv_stall = 0;
    int            beats_sent = 0;
    int            quiet = 0;
    int            n_sub = 0;
    int            n_taken = 0;
    int            n_input = 0;
    int            n_output = 0;
    logic [15:0]   pc_now = '0;
    bit            halted_now = 1'b0;
    bit            written [0:32767];
    sq_pkg::addr_t written_q[$];

    subleq_processor #(.ADDR_BITS(15)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    sq_status_check core_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_if),
        .rsp        (rsp_if),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_if.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("watchdog: no beat in %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic sq_pkg::word_t rand_word();
        case ($urandom_range(15))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_dest();
        if ($urandom_range(7) == 0)
            return 16'h7FFD + 16'($urandom_range(2));
        return 16'($urandom_range(32767));
    endfunction

    function automatic void mark_written(input sq_pkg::addr_t a);
        if (!written[a])
        begin
            written[a] = 1'b1;
            written_q.push_back(a);
        end
    endfunction

    function automatic sq_pkg::addr_t pick_written();
        return written_q[$urandom_range(written_q.size() - 1)];
    endfunction

    // any address outside the three instruction words at p0
    function automatic sq_pkg::addr_t pick_clear(input sq_pkg::addr_t p0);
        sq_pkg::addr_t x;
        do
            x = 15'($urandom_range(32767));
        while (x == p0 || x == sq_pkg::addr_t'(p0 + 1) || x == sq_pkg::addr_t'(p0 + 2));
        return x;
    endfunction

    task automatic put_beat(input sq_pkg::cmd_t op, input sq_pkg::addr_t a,
                            input sq_pkg::word_t v, input sq_pkg::byte_t ch,
                            input logic eof);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.command     <= op;
        cmd_if.address     <= a;
        cmd_if.write_value <= v;
        cmd_if.in_byte     <= ch;
        cmd_if.in_eof      <= eof;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic write_word(input sq_pkg::addr_t a, input sq_pkg::word_t v);
        put_beat(sq_pkg::CMD_LOAD, a, v, 8'($urandom), 1'($urandom));
        mark_written(a);
    endtask

    task automatic read_word(input sq_pkg::addr_t a);
        put_beat(sq_pkg::CMD_READ, a, 16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic step_core(input sq_pkg::byte_t ch, input logic eof);
        put_beat(sq_pkg::CMD_EXEC, 15'($urandom), 16'($urandom), ch, eof);
    endtask

    task automatic idle_command();
        put_beat(CMD_UNUSED, 15'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // writes one instruction at the tracked pc, its operands, then runs it
    task automatic issue_instr(input instr_t kind, input bit jump, input logic [15:0] dest,
                               input sq_pkg::byte_t ch, input logic eof);
        sq_pkg::addr_t p0;
        sq_pkg::addr_t oa;
        sq_pkg::addr_t ob;
        sq_pkg::word_t wa;
        sq_pkg::word_t wb;
        sq_pkg::word_t wc;
        sq_pkg::word_t va;
        sq_pkg::word_t diff;
        logic [15:0]   nxt;
        bit            same;
        p0 = pc_now[14:0];
        // falling through from the top would halt
        if (pc_now > 16'h7FFC && !(kind == INS_SUB && jump))
        begin
            kind = INS_SUB;
            jump = 1'b1;
            dest = 16'($urandom_range(32767));
        end
        nxt  = pc_now + 16'd3;
        wc   = 16'($urandom_range(65535));
        same = 1'b0;
        case (kind)
            INS_INPUT:
            begin
                ob = 15'($urandom_range(32767));
                wa = 16'h8000 | 16'($urandom_range(32767));
                wb = {1'b0, ob};
                n_input++;
            end
            INS_DROP:
            begin
                wa = 16'h8000 | 16'($urandom_range(32767));
                wb = 16'h8000 | 16'($urandom_range(32767));
                n_input++;
            end
            INS_OUTPUT:
            begin
                if ($urandom_range(1) == 0)
                    oa = pick_written();
                else
                begin
                    oa = pick_clear(p0);
                    write_word(oa, rand_word());
                end
                wa = {1'b0, oa};
                wb = 16'h8000 | 16'($urandom_range(32767));
                n_output++;
            end
            INS_BLIND:
            begin
                oa = pick_written();
                ob = pick_written();
                wa = {1'b0, oa};
                wb = {1'b0, ob};
                wc = pc_now + 16'd3;
                n_sub++;
            end
            default:
            begin
                oa   = pick_clear(p0);
                same = ($urandom_range(15) == 0);
                if (same)
                begin
                    ob   = oa;
                    diff = '0;
                end
                else
                begin
                    do
                        ob = pick_clear(p0);
                    while (ob == oa);
                    diff = rand_word();
                    if (jump && diff > 0)
                        diff = -diff;
                end
                va = rand_word();
                write_word(oa, va);
                if (!same)
                    write_word(ob, va + diff);
                wa = {1'b0, oa};
                wb = {1'b0, ob};
                wc = dest;
                if (diff <= 0)
                begin
                    nxt = dest;
                    n_taken++;
                end
                n_sub++;
            end
        endcase
        write_word(p0, wa);
        write_word(p0 + 15'd1, wb);
        write_word(p0 + 15'd2, wc);
        if ($urandom_range(7) == 0)
            read_word(pick_written());
        step_core(ch, eof);
        if (kind == INS_INPUT)
            mark_written(ob);
        pc_now = nxt;
        if (nxt[15])
            halted_now = 1'b1;
    endtask

    task automatic random_step();
        int roll;
        roll = $urandom_range(99);
        if (roll < 38)
            issue_instr(INS_SUB, 1'b0, rand_dest(), 8'($urandom), 1'($urandom));
        else if (roll < 52)
            issue_instr(INS_BLIND, 1'b0, 16'h0000, 8'($urandom), 1'($urandom));
        else if (roll < 64)
            issue_instr(INS_INPUT, 1'b0, 16'h0000, 8'($urandom), 1'($urandom));
        else if (roll < 69)
            issue_instr(INS_DROP, 1'b0, 16'h0000, 8'($urandom), 1'($urandom));
        else if (roll < 80)
            issue_instr(INS_OUTPUT, 1'b0, 16'h0000, 8'($urandom), 1'($urandom));
        else if (roll < 88)
            write_word(15'($urandom_range(32767)), rand_word());
        else if (roll < 96)
            read_word(pick_written());
        else
            idle_command();
    endtask

    initial
    begin
        int            stop_at;
        sq_pkg::addr_t last_addr;
        rst_n              <= 1'b0;
        cmd_if.valid       <= 1'b0;
        cmd_if.command     <= sq_pkg::CMD_LOAD;
        cmd_if.address     <= '0;
        cmd_if.write_value <= '0;
        cmd_if.in_byte     <= '0;
        cmd_if.in_eof      <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_word(15'h7FFF, 16'h7FFF);
        write_word(15'h4000, 16'h8000);
        read_word(15'h7FFF);
        read_word(15'h4000);
        idle_command();
        issue_instr(INS_INPUT, 1'b0, 16'h0000, 8'hA5, 1'b1);
        issue_instr(INS_DROP, 1'b0, 16'h0000, 8'hFF, 1'b0);
        issue_instr(INS_OUTPUT, 1'b0, 16'h0000, 8'h00, 1'b0);
        issue_instr(INS_SUB, 1'b1, 16'h7FFE, 8'h00, 1'b0);
        // instruction at the top of memory, fetch wraps to zero
        issue_instr(INS_SUB, 1'b1, 16'h0040, 8'h00, 1'b0);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 74; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 74; end
                default: begin send_idle = 29; recv_stall = 29; end
            endcase
            stop_at = beats_sent + RANDOM_BEATS / PHASES;
            while (beats_sent < stop_at)
                random_step();
            drain();
        end

        send_idle  = 0;
        recv_stall = 0;
        // jump to a negative target halts the core for good
        issue_instr(INS_SUB, 1'b1, 16'h8000 | 16'($urandom_range(32767)), 8'h00, 1'b0);
        repeat (3)
            step_core(8'($urandom), 1'($urandom));
        last_addr = 15'($urandom_range(32767));
        write_word(last_addr, rand_word());
        read_word(last_addr);
        idle_command();
        drain();
        repeat (20) @(posedge clk);

        $display("%0d beats checked over %0d commands; instructions: %0d subtract (%0d jumps),",
                 checked, beats_sent, n_sub, n_taken);
        $display("%0d input, %0d output; halt %s", n_input, n_output,
                 halted_now ? "reached" : "not reached");
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
